### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of i_clk, switched off while in reset
`define MPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
    `MPQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

### src/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and codes of the max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int KEY_W = 32;

    // Command codes
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_EXTRACTED = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Input beat
    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key;
    } t_mpq_in;

    // Result beat
    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] max_key;
    } t_mpq_out;

    // Operation broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    ext;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

### src/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted key row: keeps, takes the new key or shifts.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  logic                            i_clk,
    input  mpq_pkg::t_cell_ctl              i_ctl,
    input  logic                            i_occupied,
    input  logic                            i_left_ge,
    input  logic signed [mpq_pkg::KEY_W-1:0] i_left_key,
    input  logic signed [mpq_pkg::KEY_W-1:0] i_right_key,
    output logic signed [mpq_pkg::KEY_W-1:0] o_key,
    output logic                            o_ge
);
    import mpq_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    // Occupied and at least as large as the key being inserted
    assign o_ge  = i_occupied && (r_key >= i_ctl.key);
    assign o_key = r_key;

    // Insert: the first slot below the new key takes it, later slots shift
    // right. Extract: everything shifts left by one.
    always_comb begin
        n_key = r_key;
        priority if (i_ctl.ins) begin
            priority if (o_ge) begin
                n_key = r_key;
            end else if (i_left_ge) begin
                n_key = i_ctl.key;
            end else begin
                n_key = i_left_key;
            end
        end else if (i_ctl.ext) begin
            n_key = i_right_key;
        end else begin
            n_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

### src/max_priority_queue.sv
// ----------------------------------------------------------------------------
// max_priority_queue
// Max priority queue of signed keys held sorted in a row of cells.
// ----------------------------------------------------------------------------
// The result beat appears on o_res, marked by o_done, in the cycle after the
// command is taken. One command per cycle is taken while o_busy is low, set by
// the single compare-and-shift step that every cell makes per command.
// Reset: clears the entry count and the result strobe; o_busy is high during
// reset and until r_ready is set after it. Results are shown for one cycle only.
// ----------------------------------------------------------------------------
module max_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mpq_pkg::t_mpq_in i_cmd,
    output logic             o_busy,
    output logic             o_done,
    output mpq_pkg::t_mpq_out o_res
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_ready;
    logic              r_done;
    t_mpq_out          r_res;
    t_mpq_out          n_res;
    logic              accept;
    logic              full;
    logic              empty;
    t_cell_ctl         ctl;

    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic                    cell_ge  [CAPACITY];

    assign accept = i_start && r_ready;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign empty  = (r_count == '0);

    // Operation for the cell row
    assign ctl.ins = accept && (i_cmd.command == CMD_INSERT) && !full;
    assign ctl.ext = accept && (i_cmd.command == CMD_EXTRACT) && !empty;
    assign ctl.key = i_cmd.key;

    // Row of cells, largest key in cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    left_ge;
        logic signed [KEY_W-1:0] left_key;
        logic signed [KEY_W-1:0] right_key;
        logic                    occupied;

        assign occupied = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_ge  = 1'b1;
            assign left_key = i_cmd.key;
        end else begin : g_body
            assign left_ge  = cell_ge[g-1];
            assign left_key = cell_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_key = '0;
        end else begin : g_mid
            assign right_key = cell_key[g+1];
        end

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (occupied),
            .i_left_ge   (left_ge),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .o_key       (cell_key[g]),
            .o_ge        (cell_ge[g])
        );
    end

    // Entry count and result beat
    always_comb begin
        n_count       = r_count;
        n_res.status  = ST_INSERTED;
        n_res.max_key = '0;
        unique case (i_cmd.command)
            CMD_INSERT: begin
                if (full) begin
                    n_res.status = ST_DROPPED;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_EXTRACT: begin
                if (empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.status  = ST_EXTRACTED;
                    n_res.max_key = cell_key[0];
                    n_count       = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ready <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_busy = !r_ready;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### src/mpq_checker.sv
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpq_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mpq_pkg::t_mpq_in  i_cmd,
    input  logic              o_busy,
    input  logic              o_done,
    input  mpq_pkg::t_mpq_out o_res
);
    import mpq_pkg::*;

    logic beat;
    logic res_no_key;
    logic res_ext;

    assign beat       = i_start && !o_busy;
    assign res_no_key = o_done && (o_res.status != ST_EXTRACTED);
    assign res_ext    = o_res.status[1];

    // Every command beat gets exactly one result beat, in the next cycle
    `MPQ_ASSERT_NEXT(a_done_after_beat, beat, o_done, "result missing after command")
    `MPQ_ASSERT_NEXT(a_no_spurious_done, !beat, !o_done, "result without command")

    // Only an extraction carries a key
    `MPQ_ASSERT(a_key_zero, res_no_key |-> (o_res.max_key == '0), "key not zero")

    // An insert reports inserted or dropped, an extract extracted or empty
    `MPQ_ASSERT_NEXT(a_status_kind, beat, res_ext == $past(i_cmd.command), "wrong status kind")

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_cmd   (i_cmd),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks max_priority_queue against a heap predictor kept in the bench.
// Directed beats cover the key extremes, ties and keys below minus 2^30, plus
// extract on empty. Random traffic then works near empty, fills the queue to
// capacity (so inserts are dropped) and runs mixed traffic at the full mark.
// The sender idles in bursts. Every result is compared in order.
// ----------------------------------------------------------------------------
module testbench;

    import mpq_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int KEY_EDGE     = 1 << 30;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    typedef logic signed [KEY_W-1:0] key_t;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_mpq_in  i_cmd   = '0;
    logic     o_busy;
    logic     o_done;
    t_mpq_out o_res;

    // Bench state
    t_mpq_in  pending_beats [$];
    t_mpq_out replies_due [$];
    key_t     heap_keys [CAPACITY];
    int unsigned heap_size = 0;
    int unsigned gen_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       mismatch_count = 0;
    int       cycle_count = 0;

    max_priority_queue #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Heap predictor: applies one command, returns the reply it should give
    function automatic t_mpq_out heap_apply(input t_mpq_in beat);
        t_mpq_out    reply;
        int unsigned pos;
        int unsigned parent;
        int unsigned lc;
        int unsigned rc;
        int unsigned best;
        key_t        tmp;
        reply = '0;
        if (beat.command == CMD_INSERT) begin
            if (heap_size >= CAPACITY) begin
                reply.status = ST_DROPPED;
            end else begin
                heap_keys[heap_size] = beat.key;
                pos = heap_size;
                heap_size++;
                // sift up while the parent is strictly smaller
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[parent] >= heap_keys[pos]) break;
                    tmp = heap_keys[parent];
                    heap_keys[parent] = heap_keys[pos];
                    heap_keys[pos] = tmp;
                    pos = parent;
                end
                reply.status = ST_INSERTED;
            end
        end else if (heap_size == 0) begin
            reply.status = ST_EMPTY;
        end else begin
            reply.max_key = heap_keys[0];
            heap_size--;
            heap_keys[0] = heap_keys[heap_size];
            pos = 0;
            // sift down towards the larger child, left wins a tie
            while (1) begin
                lc = 2 * pos + 1;
                rc = lc + 1;
                best = pos;
                if (lc < heap_size && heap_keys[lc] > heap_keys[best]) best = lc;
                if (rc < heap_size && heap_keys[rc] > heap_keys[best]) best = rc;
                if (best == pos) break;
                tmp = heap_keys[pos];
                heap_keys[pos] = heap_keys[best];
                heap_keys[best] = tmp;
                pos = best;
            end
            reply.status = ST_EXTRACTED;
        end
        return reply;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Queue a beat; gen_count follows the occupancy so phases can be shaped
    task automatic add_beat(input logic command, input key_t key);
        t_mpq_in beat;
        beat.command = command;
        beat.key = key;
        pending_beats = {pending_beats, beat};
        if (command == CMD_INSERT) begin
            if (gen_count < CAPACITY) gen_count++;
        end else if (gen_count > 0) begin
            gen_count--;
        end
    endtask

    // Keys: full range, narrow band for ties, extremes, at or just below minus 2^30
    function automatic key_t pick_key();
        int v;
        case ($urandom_range(0, 5))
            0: begin
                v = $urandom_range(0, 16);
                return key_t'(v - 8);
            end
            1: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    3: return -1;
                    4: return key_t'(KEY_EDGE);
                    default: return key_t'(-KEY_EDGE);
                endcase
            end
            2: begin
                v = $urandom_range(0, 1000);
                return key_t'(-KEY_EDGE - v);
            end
            default: return key_t'($urandom);
        endcase
    endfunction

    task automatic add_mixed(input int count, input int insert_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1, 100) <= insert_pct) add_beat(CMD_INSERT, pick_key());
            else add_beat(CMD_EXTRACT, key_t'($urandom));
        end
    endtask

    // Driver: bursts of beats with random gaps between them
    always @(posedge i_clk) begin
        logic taken;
        taken = i_rst_n && i_start && !o_busy;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (taken) replies_due = {replies_due, heap_apply(i_cmd)};
            if (!i_start || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    i_start <= 1'b1;
                    i_cmd <= pending_beats.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed result against the oldest expected reply
    always @(posedge i_clk) begin
        t_mpq_out want;
        if (i_rst_n && o_done) begin
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d key %0d",
                                          o_res.status, o_res.max_key));
            end else begin
                want = replies_due.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_res.status, want.status));
                if (o_res.max_key !== want.max_key)
                    report_mismatch($sformatf("max_key %0d, expected %0d",
                                              o_res.max_key, want.max_key));
            end
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // Directed: empty extract, extremes, ties, keys below minus 2^30
        add_beat(CMD_EXTRACT, 32'sh5A5A_A5A5);
        add_beat(CMD_INSERT, 32'sh7FFF_FFFF);
        add_beat(CMD_INSERT, 32'sh8000_0000);
        add_beat(CMD_INSERT, '0);
        add_beat(CMD_INSERT, -1);
        add_beat(CMD_INSERT, key_t'(-KEY_EDGE - 1));
        add_beat(CMD_INSERT, key_t'(-KEY_EDGE));
        add_beat(CMD_INSERT, key_t'(KEY_EDGE));
        add_beat(CMD_INSERT, 5);
        add_beat(CMD_INSERT, 5);
        for (int i = 0; i < 10; i++) add_beat(CMD_EXTRACT, key_t'($urandom));
        add_beat(CMD_EXTRACT, 32'shFFFF_FFFF);

        // Random: near empty, fill to capacity, then traffic at the full mark
        add_mixed(120, 50);
        while (gen_count < CAPACITY) begin
            if ($urandom_range(1, 100) <= 94) add_beat(CMD_INSERT, pick_key());
            else add_beat(CMD_EXTRACT, key_t'($urandom));
        end
        add_mixed(4, 100);
        add_beat(CMD_EXTRACT, key_t'($urandom));
        add_mixed(4, 100);
        add_mixed(100, 50);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_start || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", replies_due.size()));
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/mpq_pkg.sv
src/mpq_cell.sv
src/max_priority_queue.sv
src/mpq_checker.sv
test/testbench.sv
